[sv/utf8_stream_decoder_macros.svh]
// Assertion macros shared by the decoder.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTFD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/utfd_pkg.sv]
package utfd_pkg;

    localparam int CP_W = 21;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_end;
    } byte_beat_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_byte;
        logic            run_last;
        logic            text_done;
    } char_beat_t;

    // Work for one input beat: some replacements for a flushed sequence,
    // then at most one closing result.
    typedef struct packed {
        logic [1:0]      flush_cnt;
        logic            has_tail;
        logic [CP_W-1:0] tail_cp;
        logic            tail_bad;
        logic            text_end;
    } run_t;

endpackage

[sv/utfd_front.sv]
module utfd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  utfd_pkg::byte_beat_t byte_data,
    input  logic                full,
    output logic                push,
    output utfd_pkg::run_t      run,
    output logic                seq_open
);

    logic [utfd_pkg::CP_W-1:0] partial_reg;
    logic [utfd_pkg::CP_W-1:0] partial_next;
    logic [1:0]                needed_reg;
    logic [1:0]                needed_next;
    logic [1:0]                gathered_reg;
    logic [1:0]                gathered_next;

    logic                      accept;
    logic [7:0]                b;
    logic                      is_cont;
    logic                      is_ascii;
    logic                      lead2;
    logic                      lead3;
    logic                      lead4;
    logic                      fresh;
    logic [1:0]                g_inc;
    logic [utfd_pkg::CP_W-1:0] shifted;

    assign byte_stall = full;
    assign accept     = byte_valid && !full;
    assign seq_open   = (needed_reg != 2'd0);

    assign b        = byte_data.data_byte;
    assign is_cont  = (b[7:6] == 2'b10);
    assign is_ascii = !b[7];
    assign lead2    = (b[7:5] == 3'b110);
    assign lead3    = (b[7:4] == 4'b1110);
    assign lead4    = (b[7:3] == 5'b11110);
    assign g_inc    = gathered_reg + 2'd1;
    assign shifted  = {partial_reg[utfd_pkg::CP_W-7:0], b[5:0]};

    always_comb
    begin
        partial_next  = partial_reg;
        needed_next   = needed_reg;
        gathered_next = gathered_reg;
        fresh         = 1'b1;
        run.flush_cnt = 2'd0;
        run.has_tail  = 1'b0;
        run.tail_cp   = utfd_pkg::REPLACEMENT_CP;
        run.tail_bad  = 1'b1;
        run.text_end  = byte_data.text_end;

        if (needed_reg != 2'd0)
        begin
            if (is_cont)
            begin
                fresh = 1'b0;
                if (g_inc == needed_reg)
                begin
                    run.has_tail  = 1'b1;
                    run.tail_cp   = shifted;
                    run.tail_bad  = 1'b0;
                    partial_next  = '0;
                    needed_next   = 2'd0;
                    gathered_next = 2'd0;
                end
                else if (byte_data.text_end)
                begin
                    run.flush_cnt = g_inc + 2'd1;
                end
                else
                begin
                    partial_next  = shifted;
                    gathered_next = g_inc;
                end
            end
            else
            begin
                run.flush_cnt = gathered_reg + 2'd1;
                partial_next  = '0;
                needed_next   = 2'd0;
                gathered_next = 2'd0;
            end
        end

        if (fresh)
        begin
            if (is_ascii)
            begin
                run.has_tail = 1'b1;
                run.tail_cp  = {{(utfd_pkg::CP_W-8){1'b0}}, b};
                run.tail_bad = 1'b0;
            end
            else if ((lead2 || lead3 || lead4) && !byte_data.text_end)
            begin
                gathered_next = 2'd0;
                if (lead2)
                begin
                    needed_next  = 2'd1;
                    partial_next = {{(utfd_pkg::CP_W-5){1'b0}}, b[4:0]};
                end
                else if (lead3)
                begin
                    needed_next  = 2'd2;
                    partial_next = {{(utfd_pkg::CP_W-4){1'b0}}, b[3:0]};
                end
                else
                begin
                    needed_next  = 2'd3;
                    partial_next = {{(utfd_pkg::CP_W-3){1'b0}}, b[2:0]};
                end
            end
            else
            begin
                run.has_tail = 1'b1;
            end
        end

        if (byte_data.text_end)
        begin
            partial_next  = '0;
            needed_next   = 2'd0;
            gathered_next = 2'd0;
        end
    end

    assign push = accept && ((run.flush_cnt != 2'd0) || run.has_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            needed_reg   <= 2'd0;
            gathered_reg <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg  <= partial_next;
            needed_reg   <= needed_next;
            gathered_reg <= gathered_next;
        end
    end

endmodule

[sv/utfd_queue.sv]
module utfd_queue #(
    parameter int DEPTH = utfd_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  utfd_pkg::run_t run_in,
    input  logic           pop,
    output utfd_pkg::run_t run_out,
    output logic           not_empty,
    output logic           full
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    utfd_pkg::run_t entry_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CntW'(DEPTH));
    assign run_out   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= run_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[sv/utfd_back.sv]
module utfd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utfd_pkg::run_t       run,
    input  logic                 not_empty,
    output logic                 pop,
    output logic                 char_valid,
    input  logic                 char_stall,
    output utfd_pkg::char_beat_t char_data
);

    logic [1:0]           idx_reg;
    logic                 valid_reg;
    utfd_pkg::char_beat_t beat_reg;
    utfd_pkg::char_beat_t beat_next;
    logic                 load;
    logic                 in_flush;
    logic                 last;

    assign load     = not_empty && (!valid_reg || !char_stall);
    assign in_flush = (idx_reg < run.flush_cnt);
    assign last     = in_flush ? ((idx_reg == run.flush_cnt - 2'd1) && !run.has_tail) : 1'b1;
    assign pop      = load && last;

    always_comb
    begin
        if (in_flush)
        begin
            beat_next.code_point = utfd_pkg::REPLACEMENT_CP;
            beat_next.bad_byte   = 1'b1;
        end
        else
        begin
            beat_next.code_point = run.tail_cp;
            beat_next.bad_byte   = run.tail_bad;
        end
        beat_next.run_last  = last;
        beat_next.text_done = last && run.text_end;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= last ? 2'd0 : idx_reg + 2'd1;
            end
            else if (!char_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign char_valid = valid_reg;
    assign char_data  = beat_reg;

endmodule

[sv/utf8_stream_decoder.sv]
// After its last byte, a code point passes the run queue and then the output register.
// One byte is taken per cycle while the run queue is not full; the output register sends
// one result per cycle unless char_stall is set, so a byte's replacements hold the queue.
// Reset clears the open sequence, the run queue and the output valid; no memory is
// cleared, and the block takes bytes in the first cycle after reset.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utfd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  utfd_pkg::byte_beat_t byte_data,
    output logic                 char_valid,
    input  logic                 char_stall,
    output utfd_pkg::char_beat_t char_data
);

    logic           push;
    logic           pop;
    logic           full;
    logic           not_empty;
    logic           seq_open;
    utfd_pkg::run_t run_in;
    utfd_pkg::run_t run_out;

    utfd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .full       (full),
        .push       (push),
        .run        (run_in),
        .seq_open   (seq_open)
    );

    utfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .run_in    (run_in),
        .pop       (pop),
        .run_out   (run_out),
        .not_empty (not_empty),
        .full      (full)
    );

    utfd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .run        (run_out),
        .not_empty  (not_empty),
        .pop        (pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    `UTFD_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full, "run pushed into a full queue")
    `UTFD_ASSERT_NEXT(a_end_closes, clk, rst_n, byte_valid && !byte_stall && byte_data.text_end, !seq_open, "sequence still open after text end")
    `UTFD_ASSERT_SAME(a_bad_is_repl, clk, rst_n, char_valid && char_data.bad_byte, char_data.code_point == utfd_pkg::REPLACEMENT_CP, "bad result without replacement value")
    `UTFD_ASSERT_SAME(a_done_is_last, clk, rst_n, char_valid && char_data.text_done, char_data.run_last, "text done on a result that is not last")

endmodule
